>>> hdl/scp_pkg.sv
// Shared types, constants and the Q.30 multiply helper of the sine/cosine pipeline.
// Depends on nothing; used by scp_reduce, scp_poly, the top module and scp_checker.
package scp_pkg;

  localparam int DEF_ANGLE_WIDTH  = 32;
  localparam int DEF_RESULT_WIDTH = 32;

  // Register stages from request to result, and the split between the two units.
  localparam int NUM_STAGES    = 10;
  localparam int REDUCE_STAGES = 4;
  localparam int POLY_STAGES   = 5;

  // Angle magnitude as an unsigned Q8.32 value.
  localparam int AQ_W = 40;
  // Quadrant index width (the index never exceeds 81).
  localparam int QUAD_W = 7;
  // Reduced angle with 32 fraction bits, signed.
  localparam int RED_W = 36;
  // Every value inside the polynomial, Q.30 signed.
  localparam int POLY_W = 34;

  typedef logic signed [POLY_W-1:0] poly_t;
  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // 2/pi with 24 fraction bits.
  localparam logic [23:0] TWO_OVER_PI_Q24 = 24'd10680707;
  // pi/2 as 201/128 plus a small remainder, 32 fraction bits.
  localparam logic [32:0] HALF_PI_Q32 = 33'd6746518852;

  localparam poly_t COEF3_Q30 = -34'sd178949812;
  localparam poly_t COEF5_Q30 = 34'sd8927412;
  localparam poly_t COEF7_Q30 = 34'sd199093;
  localparam poly_t ONE_Q30   = 34'sd1073741824;

  // Full-precision product, then an arithmetic shift by 30 (rounds toward minus infinity).
  function automatic poly_t mul_q30(input poly_t a, input poly_t b);
    logic signed [2*POLY_W-1:0] p;
    p = a * b;
    return p[POLY_W+29:30];
  endfunction

endpackage

>>> hdl/sincos_polynomial_quadrant.sv
// Ten register stages lie between an accepted request and its presented result.
// Throughput: one request per cycle while m_axis_tready is high, as each stage then loads.
// Each stage moves on when its successor is empty or moving, so bubbles collapse under stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; the data registers are not reset.
// Depends on scp_pkg, scp_reduce and scp_poly.
module sincos_polynomial_quadrant #(
  parameter int ANGLE_WIDTH  = scp_pkg::DEF_ANGLE_WIDTH,
  parameter int RESULT_WIDTH = scp_pkg::DEF_RESULT_WIDTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: angle (ANGLE_WIDTH bits, signed Q8.x), zero padding.
  input  logic [((ANGLE_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  // Fields from bit 0 up: sine_value, cosine_value (RESULT_WIDTH bits each), zero padding.
  output logic [((2*RESULT_WIDTH+7)/8)*8-1:0]    m_axis_tdata
);

  localparam int NumStages = scp_pkg::NUM_STAGES;
  localparam int RedStages = scp_pkg::REDUCE_STAGES;
  localparam int PolyStg   = scp_pkg::POLY_STAGES;
  localparam int OutTdataW = ((2*RESULT_WIDTH+7)/8)*8;
  localparam int PolyW     = scp_pkg::POLY_W;
  localparam int WideW     = PolyW + 32;
  // The polynomial output is moved to Q.62, then shifted down to RESULT_WIDTH-2 fraction bits.
  localparam int ResShift  = 64 - RESULT_WIDTH;

  // Valid bits and stage enables. A stage loads when it is empty or its successor loads.
  scp_pkg::stage_vec_t valid_q, valid_d, en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages-2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (en[0]) begin
      valid_d[0] = s_axis_tvalid;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NumStages-1];

  // Range reduction: stages 0 to 3.
  scp_pkg::poly_t x_sin, x_cos, y_sin, y_cos;
  logic           neg_red;

  scp_reduce #(
    .ANGLE_WIDTH (ANGLE_WIDTH)
  ) u_reduce (
    .clk_i   (clk_i),
    .en_i    (en[RedStages-1:0]),
    .angle_i (s_axis_tdata[ANGLE_WIDTH-1:0]),
    .x_sin_o (x_sin),
    .x_cos_o (x_cos),
    .neg_o   (neg_red)
  );

  // Polynomial lanes: stages 4 to 8, one lane for each output.
  scp_poly u_poly_sin (
    .clk_i (clk_i),
    .en_i  (en[RedStages +: PolyStg]),
    .x_i   (x_sin),
    .y_o   (y_sin)
  );

  scp_poly u_poly_cos (
    .clk_i (clk_i),
    .en_i  (en[RedStages +: PolyStg]),
    .x_i   (x_cos),
    .y_o   (y_cos)
  );

  // The sign of the angle follows the polynomial lanes stage by stage.
  logic [PolyStg-1:0] neg_dly_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PolyStg; i++) begin
      if (en[RedStages+i]) begin
        neg_dly_q[i] <= (i == 0) ? neg_red : neg_dly_q[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Stage 9: negate the sine for negative angles and scale both to the result format.
  scp_pkg::poly_t           sv;
  logic signed [WideW-1:0]  sin_wide, cos_wide, sin_shr, cos_shr;
  logic [RESULT_WIDTH-1:0]  sin_d, cos_d, sin_q, cos_q;

  assign sv       = neg_dly_q[PolyStg-1] ? -y_sin : y_sin;
  assign sin_wide = {sv, 32'b0};
  assign cos_wide = {y_cos, 32'b0};
  assign sin_shr  = sin_wide >>> ResShift;
  assign cos_shr  = cos_wide >>> ResShift;
  assign sin_d    = sin_shr[RESULT_WIDTH-1:0];
  assign cos_d    = cos_shr[RESULT_WIDTH-1:0];

  always_ff @(posedge clk_i) begin
    if (en[NumStages-1]) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign m_axis_tdata = OutTdataW'({cos_q, sin_q});

  // Checks on the stage control.
  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Any empty stage lets a new request in.
  a_ready_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(&valid_q) |-> s_axis_tready)
    else $error("input stalled although a stage is empty");

  // Items in flight change only by accepted requests and delivered results.
  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(valid_q) == $past($countones(valid_q))
              + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("item lost or duplicated in the pipeline");

  // An empty output register always takes the item behind it.
  a_output_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!valid_q[NumStages-1] && valid_q[NumStages-2]) |=> valid_q[NumStages-1])
    else $error("output stage failed to fill");

endmodule

>>> hdl/scp_reduce.sv
// Range reduction: magnitude, quadrant index, reduced angle and polynomial arguments.
// Four register stages, each loaded by its own enable. Depends on scp_pkg.
module scp_reduce #(
  parameter int ANGLE_WIDTH = scp_pkg::DEF_ANGLE_WIDTH
) (
  input  logic                                clk_i,
  input  logic [scp_pkg::REDUCE_STAGES-1:0]   en_i,
  input  logic [ANGLE_WIDTH-1:0]              angle_i,
  output scp_pkg::poly_t                      x_sin_o,
  output scp_pkg::poly_t                      x_cos_o,
  output logic                                neg_o
);

  localparam int AqW   = scp_pkg::AQ_W;
  localparam int MagW  = ANGLE_WIDTH + AqW;
  localparam int ProdW = AqW + 24;
  localparam int RedW  = scp_pkg::RED_W;
  localparam int PolyW = scp_pkg::POLY_W;

  // Stage 0: magnitude aligned to 32 fraction bits.
  logic [ANGLE_WIDTH-1:0] mag;
  logic [MagW-1:0]        mag_wide;
  logic [AqW-1:0]         a0_d, a0_q;
  logic                   n0_q;

  assign mag      = angle_i[ANGLE_WIDTH-1] ? (~angle_i + 1'b1) : angle_i;
  assign mag_wide = {mag, {AqW{1'b0}}};
  assign a0_d     = mag_wide[MagW-1 -: AqW];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      a0_q <= a0_d;
      n0_q <= angle_i[ANGLE_WIDTH-1];
    end
  end

  // Stage 1: quadrant index from the product with 2/pi.
  logic [ProdW-1:0]            prod;
  logic [scp_pkg::QUAD_W-1:0]  q1_d, q1_q;
  logic [AqW-1:0]              a1_q;
  logic                        n1_q;

  assign prod = ProdW'(a0_q) * ProdW'(scp_pkg::TWO_OVER_PI_Q24);
  assign q1_d = prod[56 +: scp_pkg::QUAD_W];

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      q1_q <= q1_d;
      a1_q <= a0_q;
      n1_q <= n0_q;
    end
  end

  // Stage 2: r = |angle| - q * pi/2.
  logic [AqW-1:0]          qhp;
  logic signed [AqW:0]     r_full;
  logic signed [RedW-1:0]  r2_d, r2_q;
  logic [1:0]              q2_q;
  logic                    n2_q;

  assign qhp    = AqW'(q1_q) * AqW'(scp_pkg::HALF_PI_Q32);
  assign r_full = $signed({1'b0, a1_q}) - $signed({1'b0, qhp});
  assign r2_d   = r_full[RedW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      r2_q <= r2_d;
      q2_q <= q1_q[1:0];
      n2_q <= n1_q;
    end
  end

  // Stage 3: offset from pi/2, drop to Q.30 and pick signed arguments by quadrant.
  logic signed [RedW-1:0] s_red;
  scp_pkg::poly_t         rq, sq, xs_d, xc_d, xs_q, xc_q;
  logic                   n3_q;

  assign s_red = r2_q - $signed(RedW'(scp_pkg::HALF_PI_Q32));
  assign rq    = r2_q[RedW-1:2];
  assign sq    = s_red[RedW-1:2];

  always_comb begin
    unique case (scp_pkg::quad_e'(q2_q))
      scp_pkg::QUAD_0: begin
        xs_d = rq;
        xc_d = -sq;
      end
      scp_pkg::QUAD_1: begin
        xs_d = -sq;
        xc_d = -rq;
      end
      scp_pkg::QUAD_2: begin
        xs_d = -rq;
        xc_d = sq;
      end
      default: begin
        xs_d = sq;
        xc_d = rq;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      xs_q <= xs_d;
      xc_q <= xc_d;
      n3_q <= n2_q;
    end
  end

  assign x_sin_o = xs_q;
  assign x_cos_o = xc_q;
  assign neg_o   = n3_q;

  // PolyW documents the argument width carried on both outputs.
  if (PolyW != $bits(scp_pkg::poly_t)) begin : g_width_check
    $error("scp_reduce: argument width mismatch");
  end

endmodule

>>> hdl/scp_poly.sv
// One lane of the odd degree-7 polynomial in Horner form, one multiply per stage.
// Five register stages, each loaded by its own enable. Depends on scp_pkg.
module scp_poly (
  input  logic                              clk_i,
  input  logic [scp_pkg::POLY_STAGES-1:0]   en_i,
  input  scp_pkg::poly_t                    x_i,
  output scp_pkg::poly_t                    y_o
);

  scp_pkg::poly_t x1_q, x2_1_q;
  scp_pkg::poly_t x2_q, x2_2_q, t1_q;
  scp_pkg::poly_t x3_q, x2_3_q, t2_q;
  scp_pkg::poly_t x4_q, t3_q;
  scp_pkg::poly_t y_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      x1_q   <= x_i;
      x2_1_q <= scp_pkg::mul_q30(x_i, x_i);
    end
    if (en_i[1]) begin
      x2_q   <= x1_q;
      x2_2_q <= x2_1_q;
      t1_q   <= scp_pkg::COEF5_Q30 - scp_pkg::mul_q30(x2_1_q, scp_pkg::COEF7_Q30);
    end
    if (en_i[2]) begin
      x3_q   <= x2_q;
      x2_3_q <= x2_2_q;
      t2_q   <= scp_pkg::COEF3_Q30 + scp_pkg::mul_q30(x2_2_q, t1_q);
    end
    if (en_i[3]) begin
      x4_q <= x3_q;
      t3_q <= scp_pkg::ONE_Q30 + scp_pkg::mul_q30(x2_3_q, t2_q);
    end
    if (en_i[4]) begin
      y_q <= scp_pkg::mul_q30(x4_q, t3_q);
    end
  end

  assign y_o = y_q;

endmodule

>>> tb/scp_checker.sv
// Checker for the sine/cosine block: watches the request and result streams,
// predicts each result from the accepted angle and compares field by field.
// Depends on scp_pkg for the quadrant enum.
`timescale 1ns / 100ps

module scp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // Fields from bit 0 up: angle (32 bits, signed Q8.24).
  input  logic [31:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // Fields from bit 0 up: sine_value, cosine_value (32 bits each, signed Q2.30).
  input  logic [63:0] m_tdata_i,
  output int          error_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] sine;
    logic [31:0] cosine;
  } sincos_t;

  localparam logic [63:0] TWO_OVER_PI_Q24 = 64'd10680707;
  localparam longint HALF_PI_Q32 = (longint'(201) <<< 25) + 64'sd2078020;
  localparam longint C3_Q30 = -64'sd178949812;
  localparam longint C5_Q30 = 64'sd8927412;
  localparam longint C7_Q30 = 64'sd199093;
  localparam longint ONE_Q30 = 64'sd1073741824;

  sincos_t expected_sincos_q[$];

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint odd_poly7(input longint x);
    longint x2;
    longint acc;
    x2  = q30_mul(x, x);
    acc = C5_Q30 - q30_mul(x2, C7_Q30);
    acc = C3_Q30 + q30_mul(x2, acc);
    acc = ONE_Q30 + q30_mul(x2, acc);
    return q30_mul(x, acc);
  endfunction

  function automatic sincos_t sincos_of_angle(input logic [31:0] angle);
    logic [31:0] mag;
    logic [63:0] angle_q32;
    logic [63:0] quad;
    longint r_q30;
    longint s_q30;
    longint sin_q30;
    longint cos_q30;
    scp_pkg::quad_e quad_sel;
    sincos_t res;
    // The most negative angle folds onto exactly 128 rad.
    mag       = angle[31] ? -angle : angle;
    angle_q32 = {24'd0, mag, 8'd0};
    quad      = (angle_q32 * TWO_OVER_PI_Q24) >> 56;
    r_q30     = (longint'(angle_q32) - HALF_PI_Q32 * longint'(quad)) >>> 2;
    s_q30     = (longint'(angle_q32) - HALF_PI_Q32 * longint'(quad) - HALF_PI_Q32) >>> 2;
    quad_sel  = scp_pkg::quad_e'(quad[1:0]);
    case (quad_sel)
      scp_pkg::QUAD_0: begin
        sin_q30 = odd_poly7(r_q30);
        cos_q30 = odd_poly7(-s_q30);
      end
      scp_pkg::QUAD_1: begin
        sin_q30 = odd_poly7(-s_q30);
        cos_q30 = odd_poly7(-r_q30);
      end
      scp_pkg::QUAD_2: begin
        sin_q30 = odd_poly7(-r_q30);
        cos_q30 = odd_poly7(s_q30);
      end
      default: begin
        sin_q30 = odd_poly7(s_q30);
        cos_q30 = odd_poly7(r_q30);
      end
    endcase
    if (angle[31]) begin
      sin_q30 = -sin_q30;
    end
    res.sine   = sin_q30[31:0];
    res.cosine = cos_q30[31:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
    error_count_o++;
  endtask

  initial begin
    error_count_o = 0;
    pending_o     = 0;
  end

  // Outputs are checked before the new request is queued; with ten stages a
  // request can never produce a result on the edge that accepts it.
  always @(posedge clk_i) begin
    sincos_t want;
    if (rst_ni) begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_sincos_q.size() == 0) begin
          report_mismatch("result with no pending request", m_tdata_i[31:0], 32'h0);
        end else begin
          want = expected_sincos_q.pop_front();
          if (m_tdata_i[31:0] !== want.sine) begin
            report_mismatch("sine_value", m_tdata_i[31:0], want.sine);
          end
          if (m_tdata_i[63:32] !== want.cosine) begin
            report_mismatch("cosine_value", m_tdata_i[63:32], want.cosine);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_sincos_q.push_back(sincos_of_angle(s_tdata_i));
      end
      pending_o = expected_sincos_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
// Top of the sine/cosine testbench: clock, reset, angle stimulus, stall patterns
// and the verdict. Depends on sincos_polynomial_quadrant and scp_checker.
`timescale 1ns / 100ps

module testbench;

  // Quadrant step: pi/2 in Q8.24, used to aim requests at quadrant boundaries.
  localparam int HALF_PI_Q24 = 26353589;
  localparam int TWO_PI_Q24 = 105414357;
  localparam int ITEMS_PER_PHASE = 360;
  // Cycles without any handshake before the run is declared hung.
  localparam int STALL_LIMIT = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;

  int error_count;
  int pending_results;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  sincos_polynomial_quadrant DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  scp_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .error_count_o (error_count),
    .pending_o     (pending_results)
  );

  // The receiver decides at each falling edge whether to stall the next cycle.
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any accepted request or result restarts the count.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Presents one angle, with a random number of idle cycles first, and returns
  // at the falling edge after it was accepted. The valid stays high between
  // back-to-back requests, so it is never lowered and raised in the same step.
  task automatic send_angle(input logic [31:0] angle);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= angle;
    do begin
      @(posedge clk_i);
    end while (!(s_tvalid && s_tready));
    @(negedge clk_i);
  endtask

  // Holds the sender off until every outstanding result has been received.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Random angles: the full range, one turn either way, hits right around a
  // quadrant boundary, and tiny magnitudes where the polynomial is near linear.
  function automatic logic [31:0] random_angle();
    logic [31:0] mag;
    int          kind;
    kind = $urandom_range(3);
    case (kind)
      0: return $urandom;
      1: mag = $urandom_range(TWO_PI_Q24);
      2: mag = $urandom_range(81) * HALF_PI_Q24 + $urandom_range(16) - 8;
      default: mag = $urandom_range(255);
    endcase
    if (kind == 2 && mag[31]) begin
      mag = '0;
    end
    return $urandom_range(1) ? -mag : mag;
  endfunction

  initial begin
    logic [31:0] directed_angles[$];
    int          phase;
    directed_angles = '{
      32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
      32'h0100_0000, 32'hFF00_0000, HALF_PI_Q24, -HALF_PI_Q24, HALF_PI_Q24 - 1,
      HALF_PI_Q24 + 1, 2 * HALF_PI_Q24, 3 * HALF_PI_Q24, 4 * HALF_PI_Q24,
      5 * HALF_PI_Q24 + 3, -(3 * HALF_PI_Q24), 32'h6400_0000, 32'h9C00_0000,
      32'h4000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0001
    };

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed corners at full rate on both sides.
    foreach (directed_angles[i]) begin
      send_angle(directed_angles[i]);
    end
    drain_results();

    // Random phases: no idling, sender gaps, receiver stalls, then both.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        send_angle(random_angle());
      end
      if (phase == 1) begin
        drain_results();
      end
    end

    s_tvalid       <= 1'b0;
    recv_stall_pct = 0;
    while (pending_results != 0) begin
      @(negedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    if (error_count == 0 && pending_results == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/scp_pkg.sv
hdl/scp_reduce.sv
hdl/scp_poly.sv
hdl/sincos_polynomial_quadrant.sv
tb/scp_checker.sv
tb/testbench.sv
